/* hdl/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, widths and constants of the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int DEF_SAMPLE_BITS   = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam int Q15_W    = 16;
    localparam int PROD_W   = 32;
    localparam int OPND_W   = 34;
    localparam int CORDIC_W = 52;
    localparam int ANG_W    = 32;
    localparam int SQ_W     = 62;
    localparam int ROOT_STEPS = 31;
    localparam int OUT_W    = 16;
    localparam int MAX_STAGES = 32;

    localparam logic [ANG_W-1:0] ANG_QUARTER  = 32'h4000_0000;
    localparam logic [ANG_W-1:0] ANG_HALF     = 32'h8000_0000;
    localparam logic [ANG_W-1:0] ANG_MQUARTER = 32'hC000_0000;

    // atan(2^-i) with a full turn equal to 2^32.
    localparam logic [ANG_W-1:0] ATAN_TAB [MAX_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [PROD_W-1:0] ww;
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] zx;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] wz;
    } prod_t;

    typedef struct packed {
        logic signed [OPND_W-1:0] roll_y;
        logic signed [OPND_W-1:0] roll_x;
        logic signed [OPND_W-1:0] yaw_y;
        logic signed [OPND_W-1:0] yaw_x;
        logic signed [PROD_W-1:0] s;
        logic                     clamped;
    } sums_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        sums_t           sums;
    } root_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ANG_W-1:0]           z;
        logic                       byp;
    } lane_t;

    typedef struct packed {
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
        logic  clamped;
    } rot_t;

    // Special cases, scaling and the pre-rotation into the right half plane.
    function automatic lane_t cordic_prep(input logic signed [OPND_W-1:0] y,
                                          input logic signed [OPND_W-1:0] x);
        lane_t l;
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        xs = {{(CORDIC_W-OPND_W){x[OPND_W-1]}}, x} <<< 16;
        ys = {{(CORDIC_W-OPND_W){y[OPND_W-1]}}, y} <<< 16;
        l.x   = xs;
        l.y   = ys;
        l.z   = '0;
        l.byp = 1'b0;
        if (x == 0 && y == 0) begin
            l.byp = 1'b1;
        end else if (x == 0) begin
            l.byp = 1'b1;
            l.z   = (y > 0) ? ANG_QUARTER : ANG_MQUARTER;
        end else if (y == 0) begin
            l.byp = 1'b1;
            l.z   = (x > 0) ? '0 : ANG_HALF;
        end else if (x < 0) begin
            if (y > 0) begin
                l.x = ys;
                l.y = -xs;
                l.z = ANG_QUARTER;
            end else begin
                l.x = -ys;
                l.y = xs;
                l.z = ANG_MQUARTER;
            end
        end
        return l;
    endfunction

    function automatic logic [OUT_W-1:0] round_angle(input logic [ANG_W-1:0] z);
        logic [ANG_W-1:0] t;
        t = z + 32'h0000_8000;
        return t[ANG_W-1:ANG_W-OUT_W];
    endfunction

    function automatic logic [OUT_W-1:0] round_pitch(input logic [ANG_W-1:0] z);
        logic signed [ANG_W+1:0] p;
        logic signed [ANG_W+1:0] q;
        p = {{2{z[ANG_W-1]}}, z} + 34'sd32768;
        q = p >>> 16;
        if (q > 34'sd16384) begin
            q = 34'sd16384;
        end else if (q < -34'sd16384) begin
            q = -34'sd16384;
        end
        return q[OUT_W-1:0];
    endfunction

endpackage

/* hdl/quaternion_to_euler_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit
// Unit quaternion to Z-Y-X roll, pitch and yaw binary angles.
// ----------------------------------------------------------------------------
// The unit takes one quaternion per clock cycle while in_stall is low and
// returns one result for each, in order. The pipeline holds the product,
// sum and squaring registers, one register per bit of the 31-step square
// root that forms cos(pitch), a CORDIC set-up register, one per CORDIC
// iteration and the output register. A stage advances when it is empty or
// when the next stage advances, so bubbles close up and new transactions
// keep entering while a result waits at the output until the stages fill.
module quaternion_to_euler_unit #(
    parameter int SAMPLE_BITS   = q2e_pkg::DEF_SAMPLE_BITS,
    parameter int CORDIC_STAGES = q2e_pkg::DEF_CORDIC_STAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [SAMPLE_BITS-1:0]          quat_w,
    input  logic [SAMPLE_BITS-1:0]          quat_x,
    input  logic [SAMPLE_BITS-1:0]          quat_y,
    input  logic [SAMPLE_BITS-1:0]          quat_z,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [q2e_pkg::OUT_W-1:0]       roll_angle,
    output logic [q2e_pkg::OUT_W-1:0]       pitch_angle,
    output logic [q2e_pkg::OUT_W-1:0]       yaw_angle,
    output logic                            pitch_clamped
);
    import q2e_pkg::*;

    localparam int ROOT_FIRST = 4;
    localparam int PREP_ST    = ROOT_FIRST + ROOT_STEPS;
    localparam int NST        = PREP_ST + CORDIC_STAGES + 1;

    logic [NST:1] valid_reg, valid_next;
    logic [NST+1:1] ready;

    root_t root_stage [ROOT_STEPS+1];
    rot_t  rot_stage  [CORDIC_STAGES+1];
    rot_t  prep_next;

    logic [OUT_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic             clamped_reg;

    // Stage handshake: a stage loads when empty or when its successor loads.
    assign ready[NST+1] = !out_stall;
    genvar k;
    generate
        for (k = 1; k <= NST; k++) begin : g_ready
            assign ready[k] = !valid_reg[k] || ready[k+1];
            if (k == 1) begin : g_first
                assign valid_next[k] = ready[k] ? in_valid : valid_reg[k];
            end else begin : g_rest
                assign valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    q2e_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .load     (ready[3:1]),
        .quat_w   (quat_w),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z),
        .root_out (root_stage[0])
    );

    generate
        for (k = 0; k < ROOT_STEPS; k++) begin : g_root
            q2e_sqrt_cell #(
                .STEP(k)
            ) u_cell (
                .clk  (clk),
                .load (ready[ROOT_FIRST+k]),
                .d    (root_stage[k]),
                .q    (root_stage[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        logic signed [OPND_W-1:0] s_ext;
        logic signed [OPND_W-1:0] c_ext;
        sums_t sm;
        sm = root_stage[ROOT_STEPS].sums;
        s_ext = {{(OPND_W-PROD_W){sm.s[PROD_W-1]}}, sm.s};
        c_ext = {1'b0, root_stage[ROOT_STEPS].root[OPND_W-2:0]};
        prep_next.roll    = cordic_prep(sm.roll_y, sm.roll_x);
        prep_next.pitch   = cordic_prep(s_ext, c_ext);
        prep_next.yaw     = cordic_prep(sm.yaw_y, sm.yaw_x);
        prep_next.clamped = sm.clamped;
    end

    always_ff @(posedge clk)
    begin
        if (ready[PREP_ST])
        begin
            rot_stage[0] <= prep_next;
        end
    end

    generate
        for (k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
            q2e_cordic_cell #(
                .STAGE(k)
            ) u_cell (
                .clk  (clk),
                .load (ready[PREP_ST+1+k]),
                .d    (rot_stage[k]),
                .q    (rot_stage[k+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ready[NST])
        begin
            roll_reg    <= round_angle(rot_stage[CORDIC_STAGES].roll.z);
            pitch_reg   <= round_pitch(rot_stage[CORDIC_STAGES].pitch.z);
            yaw_reg     <= round_angle(rot_stage[CORDIC_STAGES].yaw.z);
            clamped_reg <= rot_stage[CORDIC_STAGES].clamped;
        end
    end

    assign in_stall      = !ready[1];
    assign out_valid     = valid_reg[NST];
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign pitch_clamped = clamped_reg;

endmodule

/* hdl/q2e_front.sv */
// ----------------------------------------------------------------------------
// q2e_front
// Products, sums with the pitch clamp, and the radicand 1 - s*s, over three
// registered stages.
// ----------------------------------------------------------------------------
module q2e_front #(
    parameter int SAMPLE_BITS = q2e_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic [2:0]             load,
    input  logic [SAMPLE_BITS-1:0] quat_w,
    input  logic [SAMPLE_BITS-1:0] quat_x,
    input  logic [SAMPLE_BITS-1:0] quat_y,
    input  logic [SAMPLE_BITS-1:0] quat_z,
    output q2e_pkg::root_t         root_out
);
    import q2e_pkg::*;

    logic signed [Q15_W-1:0] w, x, y, z;
    prod_t prod_reg, prod_next;
    sums_t sums_reg, sums_next;
    root_t root_reg, root_next;

    generate
        if (SAMPLE_BITS > Q15_W) begin : g_wide
            assign w = quat_w[SAMPLE_BITS-1 -: Q15_W];
            assign x = quat_x[SAMPLE_BITS-1 -: Q15_W];
            assign y = quat_y[SAMPLE_BITS-1 -: Q15_W];
            assign z = quat_z[SAMPLE_BITS-1 -: Q15_W];
        end else if (SAMPLE_BITS < Q15_W) begin : g_narrow
            assign w = {quat_w, {(Q15_W-SAMPLE_BITS){1'b0}}};
            assign x = {quat_x, {(Q15_W-SAMPLE_BITS){1'b0}}};
            assign y = {quat_y, {(Q15_W-SAMPLE_BITS){1'b0}}};
            assign z = {quat_z, {(Q15_W-SAMPLE_BITS){1'b0}}};
        end else begin : g_same
            assign w = quat_w;
            assign x = quat_x;
            assign y = quat_y;
            assign z = quat_z;
        end
    endgenerate

    always_comb
    begin
        prod_next.ww = w * w;
        prod_next.xx = x * x;
        prod_next.yy = y * y;
        prod_next.zz = z * z;
        prod_next.yz = y * z;
        prod_next.wx = w * x;
        prod_next.wy = w * y;
        prod_next.zx = z * x;
        prod_next.xy = x * y;
        prod_next.wz = w * z;
    end

    function automatic logic signed [OPND_W-1:0] ext(input logic signed [PROD_W-1:0] v);
        return {{(OPND_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    always_comb
    begin
        logic signed [OPND_W-1:0] s_raw;
        sums_next.roll_y = (ext(prod_reg.yz) + ext(prod_reg.wx)) <<< 1;
        sums_next.roll_x = ext(prod_reg.ww) - ext(prod_reg.xx) - ext(prod_reg.yy)
                         + ext(prod_reg.zz);
        sums_next.yaw_y  = (ext(prod_reg.xy) + ext(prod_reg.wz)) <<< 1;
        sums_next.yaw_x  = ext(prod_reg.ww) + ext(prod_reg.xx) - ext(prod_reg.yy)
                         - ext(prod_reg.zz);
        s_raw = (ext(prod_reg.wy) - ext(prod_reg.zx)) <<< 1;
        sums_next.clamped = 1'b0;
        sums_next.s = s_raw[PROD_W-1:0];
        // The asin argument is held to the unit interval.
        if (s_raw > 34'sd1073741824) begin
            sums_next.s = 32'sd1073741824;
            sums_next.clamped = 1'b1;
        end else if (s_raw < -34'sd1073741824) begin
            sums_next.s = -32'sd1073741824;
            sums_next.clamped = 1'b1;
        end
    end

    always_comb
    begin
        logic signed [2*PROD_W-1:0] sq;
        sq = sums_reg.s * sums_reg.s;
        root_next.rem  = (SQ_W'(1) << 60) - sq[SQ_W-1:0];
        root_next.root = '0;
        root_next.sums = sums_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            prod_reg <= prod_next;
        end
        if (load[1])
        begin
            sums_reg <= sums_next;
        end
        if (load[2])
        begin
            root_reg <= root_next;
        end
    end

    assign root_out = root_reg;

endmodule

/* hdl/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One bit of the restoring integer square root, registered.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           load,
    input  q2e_pkg::root_t d,
    output q2e_pkg::root_t q
);
    import q2e_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * STEP);

    root_t state_reg, state_next;

    always_comb
    begin
        logic [SQ_W-1:0] trial;
        trial = d.root + BIT;
        state_next = d;
        if (d.rem >= trial) begin
            state_next.rem  = d.rem - trial;
            state_next.root = (d.root >> 1) + BIT;
        end else begin
            state_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

/* hdl/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC iteration for the roll, pitch and yaw lanes.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          clk,
    input  logic          load,
    input  q2e_pkg::rot_t d,
    output q2e_pkg::rot_t q
);
    import q2e_pkg::*;

    rot_t state_reg, state_next;

    function automatic lane_t iterate(input lane_t l);
        lane_t r;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        dx = l.y >>> STAGE;
        dy = l.x >>> STAGE;
        r = l;
        // Lanes settled by a special case keep their angle.
        if (!l.byp) begin
            if (l.y > 0) begin
                r.x = l.x + dx;
                r.y = l.y - dy;
                r.z = l.z + ATAN_TAB[STAGE];
            end else begin
                r.x = l.x - dx;
                r.y = l.y + dy;
                r.z = l.z - ATAN_TAB[STAGE];
            end
        end
        return r;
    endfunction

    always_comb
    begin
        state_next.roll    = iterate(d.roll);
        state_next.pitch   = iterate(d.pitch);
        state_next.yaw     = iterate(d.yaw);
        state_next.clamped = d.clamped;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign q = state_reg;

endmodule

/* tb/tb_quaternion_to_euler_unit.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_unit
// Self-checking bench for the quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
// Directed corner quaternions and then random ones, unit length for the most
// part, are driven through a valid/stall channel with random gaps. A local
// model computes roll, pitch and yaw for every accepted transaction, and the
// monitor compares each result with the oldest expected angle set.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import q2e_pkg::*;

    localparam int N_RANDOM    = 950;
    localparam int DRAIN       = 60;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic        clamped;
    } euler_t;

    // atan(2^-i), a full turn being 2^32.
    localparam longint ATAN_STEP [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] quat_w;
    logic [15:0] quat_x;
    logic [15:0] quat_y;
    logic [15:0] quat_z;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] roll_angle;
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
    logic        pitch_clamped;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int     error_count;
    int     cycle_count;
    bit     calm_phase;
    bit     hold_sender;
    bit     stimulus_done;

    quaternion_to_euler_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint shr_floor(longint v, int k);
        return v >>> k;
    endfunction

    // Vectoring CORDIC; the result is a 32-bit binary angle.
    function automatic logic [31:0] vector_angle(longint y, longint x);
        longint      t;
        longint      dx;
        longint      dy;
        logic [31:0] ang;
        ang = '0;
        if (x == 0 && y == 0) return '0;
        if (x == 0) return (y > 0) ? 32'h4000_0000 : 32'hC000_0000;
        if (y == 0) return (x > 0) ? 32'h0 : 32'h8000_0000;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y; y = -t; ang = 32'h4000_0000;
            end else begin
                x = -y; y = t; ang = 32'hC000_0000;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx; y -= dy; ang += ATAN_STEP[i][31:0];
            end else begin
                x -= dx; y += dy; ang -= ATAN_STEP[i][31:0];
            end
        end
        return ang;
    endfunction

    function automatic longint floor_root(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b; r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] round_half_up(logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h8000;
        return t[31:16];
    endfunction

    function automatic euler_t predict_angles(quat_t q);
        euler_t      e;
        longint      w;
        longint      x;
        longint      y;
        longint      z;
        longint      s;
        longint      c;
        longint      p;
        logic [31:0] a;
        w = q.w; x = q.x; y = q.y; z = q.z;
        e.clamped = 1'b0;
        e.roll = round_half_up(vector_angle(2 * (y * z + w * x),
                                            w * w - x * x - y * y + z * z));
        s = 2 * (w * y - z * x);
        if (s > (64'sd1 <<< 30)) begin
            s = 64'sd1 <<< 30; e.clamped = 1'b1;
        end
        if (s < -(64'sd1 <<< 30)) begin
            s = -(64'sd1 <<< 30); e.clamped = 1'b1;
        end
        c = floor_root((64'sd1 <<< 60) - s * s);
        a = vector_angle(s, c);
        p = longint'(signed'(a));
        p = (p + 32768) >>> 16;
        if (p > 16384) p = 16384;
        if (p < -16384) p = -16384;
        e.pitch = p[15:0];
        e.yaw = round_half_up(vector_angle(2 * (x * y + w * z),
                                           w * w + x * x - y * y - z * z));
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycle_count);
    endtask

    function automatic logic signed [15:0] rand_q15();
        return 16'($urandom);
    endfunction

    function automatic quat_t make_quat(int w, int x, int y, int z);
        quat_t q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    // Random quaternion scaled to unit length, with a small perturbation.
    function automatic quat_t random_unit_quat();
        real   v[4];
        real   n;
        quat_t q;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            v[i] = real'($urandom_range(0, 20000)) - 10000.0;
            n += v[i] * v[i];
        end
        if (n == 0.0) begin
            v[0] = 1.0; n = 1.0;
        end
        n = $sqrt(n);
        q.w = 16'($rtoi(v[0] / n * 32767.0) + $urandom_range(0, 6) - 3);
        q.x = 16'($rtoi(v[1] / n * 32767.0) + $urandom_range(0, 6) - 3);
        q.y = 16'($rtoi(v[2] / n * 32767.0) + $urandom_range(0, 6) - 3);
        q.z = 16'($rtoi(v[3] / n * 32767.0) + $urandom_range(0, 6) - 3);
        return q;
    endfunction

    initial begin
        quat_t q;
        rst_n = 1'b0;
        calm_phase = 1'b0;
        hold_sender = 1'b0;
        stimulus_done = 1'b0;
        error_count = 0;
        // Identity, single axes, both signs, full scale and the zero quaternion.
        pending_quats.push_back(make_quat(32767, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(0, 32767, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 32767, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 32767));
        pending_quats.push_back(make_quat(0, -32768, 0, 0));
        pending_quats.push_back(make_quat(-32768, 0, 0, 0));
        // Gimbal lock: pitch argument at and past plus and minus one, then roll and yaw quarter turns and tiny values.
        pending_quats.push_back(make_quat(23170, 0, 23170, 0));
        pending_quats.push_back(make_quat(23170, 0, -23170, 0));
        pending_quats.push_back(make_quat(32767, 0, 32767, 0));
        pending_quats.push_back(make_quat(32767, 0, -32768, 0));
        pending_quats.push_back(make_quat(0, 32767, 0, -32768));
        pending_quats.push_back(make_quat(23170, 23170, 0, 0));
        pending_quats.push_back(make_quat(23170, -23170, 0, 0));
        pending_quats.push_back(make_quat(23170, 0, 0, 23170));
        pending_quats.push_back(make_quat(23170, 0, 0, -23170));
        pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
        pending_quats.push_back(make_quat(1, -1, 1, -1));
        pending_quats.push_back(make_quat(-1, 1, -1, 1));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                q.w = rand_q15(); q.x = rand_q15(); q.y = rand_q15(); q.z = rand_q15();
            end else begin
                q = random_unit_quat();
            end
            pending_quats.push_back(q);
        end
        // Let the sender stop until the pipeline has drained once.
        wait (pending_quats.size() < 500);
        @(posedge clk);
        hold_sender <= 1'b1;
        wait (expected_angles.size() == 0);
        @(posedge clk);
        hold_sender <= 1'b0;
        wait (pending_quats.size() < 300);
        calm_phase <= 1'b1;
        wait (pending_quats.size() < 150);
        calm_phase <= 1'b0;
        wait (pending_quats.size() == 0 && !(in_valid && in_stall) && !in_valid);
        wait (expected_angles.size() == 0);
        repeat (DRAIN) @(posedge clk);
        stimulus_done = 1'b1;
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Driver: a transaction moves when valid is high and stall is low.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            quat_w <= '0; quat_x <= '0; quat_y <= '0; quat_z <= '0;
        end else begin
            if (in_valid && !in_stall)
                expected_angles.push_back(predict_angles(make_quat(
                    $signed(quat_w), $signed(quat_x), $signed(quat_y), $signed(quat_z))));
            if (!in_valid || !in_stall) begin
                if (pending_quats.size() > 0 && !hold_sender &&
                    (calm_phase || $urandom_range(0, 99) >= 36)) begin
                    quat_w <= pending_quats[0].w;
                    quat_x <= pending_quats[0].x;
                    quat_y <= pending_quats[0].y;
                    quat_z <= pending_quats[0].z;
                    void'(pending_quats.pop_front());
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver-side stall.
    always @(posedge clk or negedge rst_n) begin
        euler_t e;
        if (!rst_n) begin
            out_stall <= 1'b0;
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            out_stall <= calm_phase ? 1'b0 : ($urandom_range(0, 99) < 36);
            if (out_valid && !out_stall) begin
                if (expected_angles.size() == 0) begin
                    error_count++;
                    $display("unexpected result at cycle %0d", cycle_count);
                end else begin
                    e = expected_angles.pop_front();
                    if (roll_angle !== e.roll) report_mismatch("roll", roll_angle, e.roll);
                    if (pitch_angle !== e.pitch)
                        report_mismatch("pitch", pitch_angle, e.pitch);
                    if (yaw_angle !== e.yaw) report_mismatch("yaw", yaw_angle, e.yaw);
                    if (pitch_clamped !== e.clamped)
                        report_mismatch("clamp", 16'(pitch_clamped), 16'(e.clamped));
                end
            end
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout at cycle %0d", cycle_count);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
hdl/q2e_pkg.sv
hdl/q2e_front.sv
hdl/q2e_sqrt_cell.sv
hdl/q2e_cordic_cell.sv
hdl/quaternion_to_euler_unit.sv
tb/tb_quaternion_to_euler_unit.sv
